@@ hw/rtl/hkm_pkg.sv @@
// ----------------------------------------------------------------------------
// hkm_pkg
// Shared constants, types and the key compare for the k-way merge heap.
// ----------------------------------------------------------------------------
package hkm_pkg;

  localparam int NUM_STREAMS = 16;
  localparam int KEY_BITS    = 64;
  localparam int DATA_BITS   = 32;
  localparam int STREAM_BITS = 4;
  localparam int IDX_W       = $clog2(NUM_STREAMS);
  localparam int CNT_W       = $clog2(NUM_STREAMS + 1);
  localparam int CHILD_W     = IDX_W + 1;
  localparam int ENT_W       = KEY_BITS + DATA_BITS + STREAM_BITS;
  localparam int PADDR_W     = 3;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_BUILD   = 2'd1,
    FUNC_REPLACE = 2'd2,
    FUNC_REMOVE  = 2'd3
  } func_t;

  typedef enum logic {
    REG_SIGNED_CMP = 1'b0,
    REG_NONE       = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BNEXT,
    ST_FETCH,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_SIFT_SWP,
    ST_SIFT_END,
    ST_RD_ROOT,
    ST_ROOT
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [DATA_BITS-1:0]   data;
    logic [STREAM_BITS-1:0] stream;
  } entry_t;

  // a >= b under unsigned or two's complement order
  function automatic logic key_ge(input logic [KEY_BITS-1:0] a,
                                  input logic [KEY_BITS-1:0] b,
                                  input logic                sgn);
    logic [KEY_BITS-1:0] fa;
    logic [KEY_BITS-1:0] fb;
    fa = a;
    fb = b;
    if (sgn) begin
      fa[KEY_BITS-1] = ~a[KEY_BITS-1];
      fb[KEY_BITS-1] = ~b[KEY_BITS-1];
    end
    return fa >= fb;
  endfunction

endpackage

@@ hw/rtl/hkm_ram.sv @@
// ----------------------------------------------------------------------------
// hkm_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module hkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hw/rtl/heap_kway_merge.sv @@
// ----------------------------------------------------------------------------
// heap_kway_merge
// K-way merge engine on a binary min-heap of stream heads.
// ----------------------------------------------------------------------------
// Items are taken one at a time: in_stall holds off the next until the last is done. A load
// or an item with nothing to sift goes straight to the root read; replace/remove fetch an entry
// and sift it down level by level; build sifts each parent node in turn, last parent first.
// The result becomes valid in the same cycle as the next item can be taken; a stalled result
// holds the sequencer. One shared key comparator and the heap RAM ports.
// Reset (rst, synchronous): heap empty, unsigned order, no result pending.
module heap_kway_merge
  import hkm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             func,
  input  logic [KEY_BITS-1:0]    rec_key,
  input  logic [DATA_BITS-1:0]   rec_data,
  input  logic [STREAM_BITS-1:0] rec_stream,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   empty_res,
  output logic [KEY_BITS-1:0]    top_key,
  output logic [DATA_BITS-1:0]   top_data,
  output logic [STREAM_BITS-1:0] top_stream,
  output logic                   overflow
);

  state_t               state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [IDX_W-1:0]     node, node_next;
  logic [IDX_W-1:0]     bidx, bidx_next;
  logic [IDX_W-1:0]     cidx, cidx_next;
  logic                 two, two_next;
  func_t                op, op_next;
  logic [KEY_BITS-1:0]  key_in, key_in_next;
  logic [DATA_BITS-1:0] data_in, data_in_next;
  entry_t               cur, cur_next;
  entry_t               child, child_next;
  logic                 over, over_next;
  logic                 signed_compare;

  logic                 we;
  logic [IDX_W-1:0]     waddr, raddr_a, raddr_b;
  entry_t               wdata, rdata_a, rdata_b;
  logic [ENT_W-1:0]     rd_a_bits, rd_b_bits;
  logic [KEY_BITS-1:0]  cmp_a, cmp_b;
  logic                 ge;
  logic [CHILD_W-1:0]   c_pos, last_pos;
  logic                 in_acc, root_load;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_compare <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx_t'(paddr[2]) == REG_SIGNED_CMP) begin
      signed_compare <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx_t'(paddr[2]) == REG_SIGNED_CMP) begin
      prdata[0] = signed_compare;
    end
  end

  hkm_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_STREAMS)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rd_a_bits),
    .rdata_b(rd_b_bits)
  );

  assign rdata_a = entry_t'(rd_a_bits);
  assign rdata_b = entry_t'(rd_b_bits);

  // shared comparator
  assign ge = key_ge(cmp_a, cmp_b, signed_compare);

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign c_pos    = {node, 1'b1};
  assign last_pos = CHILD_W'(count) - CHILD_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    node    <= node_next;
    bidx    <= bidx_next;
    cidx    <= cidx_next;
    two     <= two_next;
    op      <= op_next;
    key_in  <= key_in_next;
    data_in <= data_in_next;
    cur     <= cur_next;
    child   <= child_next;
    over    <= over_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    node_next    = node;
    bidx_next    = bidx;
    cidx_next    = cidx;
    two_next     = two;
    op_next      = op;
    key_in_next  = key_in;
    data_in_next = data_in;
    cur_next     = cur;
    child_next   = child;
    over_next    = over;
    we           = 1'b0;
    waddr        = node;
    wdata        = cur;
    raddr_a      = '0;
    raddr_b      = '0;
    cmp_a        = rdata_a.key;
    cmp_b        = rdata_b.key;
    root_load    = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          op_next      = func_t'(func);
          key_in_next  = rec_key;
          data_in_next = rec_data;
          over_next    = 1'b0;
          node_next    = '0;
          state_next   = ST_RD_ROOT;
          unique case (func_t'(func))
            FUNC_LOAD: begin
              if (count < CNT_W'(NUM_STREAMS)) begin
                we         = 1'b1;
                waddr      = count[IDX_W-1:0];
                wdata      = '{key: rec_key, data: rec_data, stream: rec_stream};
                count_next = count + CNT_W'(1);
              end else begin
                over_next = 1'b1;
              end
            end
            FUNC_BUILD: begin
              if (count >= CNT_W'(2)) begin
                bidx_next  = IDX_W'(count >> 1);
                state_next = ST_BNEXT;
              end
            end
            FUNC_REPLACE: begin
              if (count != '0) begin
                state_next = ST_FETCH;
              end
            end
            FUNC_REMOVE: begin
              if (count != '0) begin
                count_next = count - CNT_W'(1);
                raddr_a    = count_next[IDX_W-1:0];
                if (count_next != '0) begin
                  state_next = ST_FETCH;
                end
              end
            end
            default: state_next = ST_RD_ROOT;
          endcase
        end
      end
      ST_BNEXT: begin
        node_next  = bidx - IDX_W'(1);
        bidx_next  = bidx - IDX_W'(1);
        raddr_a    = node_next;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        cur_next = rdata_a;
        if (op == FUNC_REPLACE) begin
          cur_next.key  = key_in;
          cur_next.data = data_in;
        end
        state_next = ST_SIFT_RD;
      end
      ST_SIFT_RD: begin
        cidx_next = c_pos[IDX_W-1:0];
        if (c_pos < last_pos) begin
          raddr_a    = c_pos[IDX_W-1:0];
          raddr_b    = c_pos[IDX_W-1:0] + IDX_W'(1);
          two_next   = 1'b1;
          state_next = ST_SIFT_CMP;
        end else if (c_pos == last_pos) begin
          raddr_a    = c_pos[IDX_W-1:0];
          raddr_b    = c_pos[IDX_W-1:0];
          two_next   = 1'b0;
          state_next = ST_SIFT_CMP;
        end else begin
          we         = 1'b1;
          state_next = ST_SIFT_END;
        end
      end
      ST_SIFT_CMP: begin
        // ties go to the right child
        if (two && ge) begin
          child_next = rdata_b;
          cidx_next  = cidx + IDX_W'(1);
        end else begin
          child_next = rdata_a;
        end
        state_next = ST_SIFT_SWP;
      end
      ST_SIFT_SWP: begin
        cmp_a = cur.key;
        cmp_b = child.key;
        we    = 1'b1;
        if (ge) begin
          wdata      = child;
          node_next  = cidx;
          state_next = ST_SIFT_RD;
        end else begin
          state_next = ST_SIFT_END;
        end
      end
      ST_SIFT_END: begin
        if (op == FUNC_BUILD && bidx != '0) begin
          state_next = ST_BNEXT;
        end else begin
          state_next = ST_RD_ROOT;
        end
      end
      ST_RD_ROOT: begin
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (!(out_valid && out_stall)) begin
          root_load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (root_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (root_load) begin
      overflow <= over;
      if (count == '0) begin
        empty_res  <= 1'b1;
        top_key    <= '0;
        top_data   <= '0;
        top_stream <= '0;
      end else begin
        empty_res  <= 1'b0;
        top_key    <= rdata_a.key;
        top_data   <= rdata_a.data;
        top_stream <= rdata_a.stream;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_STREAMS))
    else $error("live count above heap size");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (root_load && over) |-> (count == CNT_W'(NUM_STREAMS)))
    else $error("overflow reported with free heap slots");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_res) |-> (top_key == '0 && top_data == '0 && top_stream == '0))
    else $error("empty result carries a record");

  a_sift_size: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIFT_SWP) |-> (CHILD_W'(cidx) < CHILD_W'(count)))
    else $error("sift child beyond live entries");

endmodule
